@@ sv/bads_pkg.sv @@
`default_nettype none
package bads_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int SCALE_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  typedef struct packed {
    logic close_block;
    logic first_row;
    logic emit;
    logic row_end;
    logic frame_end;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_UPDATE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

@@ sv/bads_pix_if.sv @@
`default_nettype none
interface bads_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bads_pkg::PIX_W-1:0] pixel_blue;
  logic [bads_pkg::PIX_W-1:0] pixel_green;
  logic [bads_pkg::PIX_W-1:0] pixel_red;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface
`default_nettype wire

@@ sv/bads_avg_if.sv @@
`default_nettype none
interface bads_avg_if;
  logic                       valid;
  logic                       ready;
  logic [bads_pkg::PIX_W-1:0] avg_blue;
  logic [bads_pkg::PIX_W-1:0] avg_green;
  logic [bads_pkg::PIX_W-1:0] avg_red;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, avg_blue, avg_green, avg_red, row_end, frame_end,
                  input ready);
  modport sink (input valid, avg_blue, avg_green, avg_red, row_end, frame_end,
                output ready);
endinterface
`default_nettype wire

@@ sv/box_average_downsample_core.sv @@
`default_nettype none
// Flow: a pixel that closes no block is popped from the queue and added to the block row
// sums; one that closes a block row segment also goes through B_READ and B_UPDATE into the
// line store; one that completes a block then goes through B_DIV, a bit-serial division over
// SUM_W bits (SUM_W = 20 at MAX_SCALE 64), and B_OUT, which waits out any output stall.
// The back end pops only in B_IDLE; the 4-word queue takes 1 pixel per cycle until full.
// Reset: synchronous, active high; registers return to 4096 x 4096, scale 1.
module box_average_downsample_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 64
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [bads_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [bads_pkg::CFG_W-1:0]      cfg_data,
  bads_pix_if.sink                        pixel_in,
  bads_avg_if.source                      avg_out
);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CNT = $clog2(MAX_SCALE*MAX_SCALE + 1);
  localparam int PW3 = 3*bads_pkg::PIX_W;
  localparam int DW  = bads_pkg::FLAGS_W + CW + CNT + PW3;

  bads_pkg::cmd_flags_t f_flags, q_flags;
  logic [CW-1:0]  f_index, q_index;
  logic [CNT-1:0] f_count, q_count;
  logic [PW3-1:0] q_pixel;
  logic [DW-1:0]  q_data;
  logic           full, q_valid, q_pop, accept;
  logic           cfg_hit;

  assign pixel_in.ready = !full;
  assign accept = pixel_in.valid && !full;

  // only a write to a known register restarts the frame
  assign cfg_hit = cfg_we && (cfg_index == bads_pkg::REG_FRAME_WIDTH ||
                              cfg_index == bads_pkg::REG_FRAME_HEIGHT ||
                              cfg_index == bads_pkg::REG_SCALE_FACTOR);

  bads_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_SCALE(MAX_SCALE)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .accept,
    .flags(f_flags), .block_index(f_index), .count(f_count)
  );

  bads_queue #(.DW(DW)) u_queue (
    .clk, .rst,
    .push(accept),
    .push_data({f_flags, f_index, f_count,
                pixel_in.pixel_red, pixel_in.pixel_green, pixel_in.pixel_blue}),
    .full,
    .pop(q_pop),
    .not_empty(q_valid),
    .pop_data(q_data)
  );

  assign {q_flags, q_index, q_count, q_pixel} = q_data;

  bads_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_SCALE(MAX_SCALE)) u_back (
    .clk, .rst,
    .clear(cfg_hit),
    .q_valid, .q_pop, .q_flags, .q_index, .q_count, .q_pixel,
    .avg_out
  );
endmodule
`default_nettype wire

@@ sv/bads_front.sv @@
`default_nettype none
module bads_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [bads_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [bads_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                 accept,
  output bads_pkg::cmd_flags_t                flags,
  output logic [$clog2(MAX_WIDTH)-1:0]        block_index,
  output logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0] count
);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SW  = $clog2(MAX_SCALE + 1);
  localparam int CNT = $clog2(MAX_SCALE*MAX_SCALE + 1);

  logic [WW-1:0] width_c;
  logic [HW-1:0] height_c;
  logic [SW-1:0] scale_c;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SW-1:0] cmod;
  logic [SW-1:0] rmod;
  logic [CW-1:0] bx;
  logic [SW-1:0] bw_cur;
  logic [SW-1:0] bh_cur;

  logic          last_col, last_row, cmod_last, rmod_last;
  logic [SW-1:0] bw_eff, bh_eff;
  logic [31:0]   w_rem, h_rem;

  function automatic logic [31:0] clamp_reg(input logic [bads_pkg::CFG_W-1:0] v,
                                            input int hi);
    logic [31:0] r;
    r = 32'(v);
    if (v == '0) r = 32'd1;
    else if (r > 32'(hi)) r = 32'(hi);
    return r;
  endfunction

  always_comb begin
    last_col  = (32'(col) == 32'(width_c) - 32'd1);
    last_row  = (32'(row) == 32'(height_c) - 32'd1);
    cmod_last = (cmod == scale_c - SW'(1));
    rmod_last = (rmod == scale_c - SW'(1));
    w_rem     = 32'(width_c) - 32'(col);
    h_rem     = 32'(height_c) - 32'(row);
    bw_eff    = bw_cur;
    if (cmod == '0) bw_eff = (32'(scale_c) < w_rem) ? scale_c : SW'(w_rem);
    bh_eff    = bh_cur;
    if (rmod == '0 && col == '0) bh_eff = (32'(scale_c) < h_rem) ? scale_c : SW'(h_rem);
    flags.close_block = cmod_last || last_col;
    flags.first_row   = (rmod == '0);
    flags.emit        = (cmod_last || last_col) && (rmod_last || last_row);
    flags.row_end     = last_col;
    flags.frame_end   = last_col && last_row;
    block_index       = bx;
    count             = CNT'(bw_eff) * CNT'(bh_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_c  <= WW'(clamp_reg(bads_pkg::CFG_W'(4096), MAX_WIDTH));
      height_c <= HW'(clamp_reg(bads_pkg::CFG_W'(4096), MAX_HEIGHT));
      scale_c  <= SW'(1);
      col  <= '0;
      row  <= '0;
      cmod <= '0;
      rmod <= '0;
      bx   <= '0;
      bw_cur <= '0;
      bh_cur <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bads_pkg::REG_FRAME_WIDTH:  width_c  <= WW'(clamp_reg(cfg_data, MAX_WIDTH));
        bads_pkg::REG_FRAME_HEIGHT: height_c <= HW'(clamp_reg(cfg_data, MAX_HEIGHT));
        bads_pkg::REG_SCALE_FACTOR:
          scale_c <= SW'(clamp_reg(bads_pkg::CFG_W'(cfg_data[bads_pkg::SCALE_W-1:0]),
                                   MAX_SCALE));
        default: ;
      endcase
      if (cfg_index == bads_pkg::REG_FRAME_WIDTH || cfg_index == bads_pkg::REG_FRAME_HEIGHT
          || cfg_index == bads_pkg::REG_SCALE_FACTOR) begin
        col  <= '0;
        row  <= '0;
        cmod <= '0;
        rmod <= '0;
        bx   <= '0;
      end
    end else if (accept) begin
      bw_cur <= bw_eff;
      bh_cur <= bh_eff;
      if (last_col) begin
        col  <= '0;
        cmod <= '0;
        bx   <= '0;
        if (last_row) begin
          row  <= '0;
          rmod <= '0;
        end else begin
          row  <= row + RW'(1);
          rmod <= rmod_last ? '0 : rmod + SW'(1);
        end
      end else begin
        col  <= col + CW'(1);
        cmod <= cmod_last ? '0 : cmod + SW'(1);
        if (cmod_last) bx <= bx + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/bads_queue.sv @@
`default_nettype none
module bads_queue #(
  parameter int DW = 8
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  wire  [DW-1:0] push_data,
  output logic          full,
  input  wire           pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);
  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DW-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;

  assign full      = (fill == (AW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop) fill <= fill + (AW+1)'(1);
      else if (pop && !push) fill <= fill - (AW+1)'(1);
    end
  end
endmodule
`default_nettype wire

@@ sv/bads_back.sv @@
`default_nettype none
module bads_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 64
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  clear,
  input  wire                                  q_valid,
  output logic                                 q_pop,
  input  bads_pkg::cmd_flags_t                 q_flags,
  input  wire  [$clog2(MAX_WIDTH)-1:0]         q_index,
  input  wire  [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0] q_count,
  input  wire  [3*bads_pkg::PIX_W-1:0]         q_pixel,
  bads_avg_if.source                           avg_out
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CNT   = $clog2(MAX_SCALE*MAX_SCALE + 1);
  localparam int SUM_W = $clog2(255*MAX_SCALE*MAX_SCALE + 1);
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam int PW    = bads_pkg::PIX_W;

  bads_pkg::back_state_t state, state_next;

  logic [3*SUM_W-1:0]   mem [MAX_WIDTH];
  logic [3*SUM_W-1:0]   rd_data;
  logic [SUM_W-1:0]     brs [3];
  logic [SUM_W-1:0]     new_sum [3];
  logic [SUM_W-1:0]     quo [3];
  logic [CNT-1:0]       rem [3];
  logic [CNT:0]         rem_sh [3];
  logic [CNT:0]         diff [3];
  logic [CW-1:0]        idx;
  logic [CNT-1:0]       divisor;
  bads_pkg::cmd_flags_t cur;
  logic [DCW-1:0]       dcnt;
  logic                 out_free;

  assign out_free = !avg_out.valid || avg_out.ready;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      new_sum[c] = cur.first_row ? brs[c] : rd_data[c*SUM_W +: SUM_W] + brs[c];
      rem_sh[c]  = {rem[c], quo[c][SUM_W-1]};
      diff[c]    = rem_sh[c] - {1'b0, divisor};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bads_pkg::B_IDLE:   if (q_valid && q_flags.close_block) state_next = bads_pkg::B_READ;
      bads_pkg::B_READ:   state_next = bads_pkg::B_UPDATE;
      bads_pkg::B_UPDATE: state_next = cur.emit ? bads_pkg::B_DIV : bads_pkg::B_IDLE;
      bads_pkg::B_DIV:    if (dcnt == DCW'(SUM_W - 1)) state_next = bads_pkg::B_OUT;
      bads_pkg::B_OUT:    if (out_free) state_next = bads_pkg::B_IDLE;
      default:            state_next = bads_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == bads_pkg::B_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bads_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == bads_pkg::B_READ) rd_data <= mem[idx];
    if (state == bads_pkg::B_UPDATE)
      mem[idx] <= {new_sum[2], new_sum[1], new_sum[0]};
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int c = 0; c < 3; c++) brs[c] <= '0;
    end else if (q_pop) begin
      for (int c = 0; c < 3; c++) brs[c] <= brs[c] + SUM_W'(q_pixel[c*PW +: PW]);
    end else if (state == bads_pkg::B_UPDATE) begin
      for (int c = 0; c < 3; c++) brs[c] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_flags;
      idx     <= q_index;
      divisor <= q_count;
    end
    case (state)
      bads_pkg::B_UPDATE: begin
        dcnt <= '0;
        for (int c = 0; c < 3; c++) begin
          quo[c] <= new_sum[c];
          rem[c] <= '0;
        end
      end
      bads_pkg::B_DIV: begin
        dcnt <= dcnt + DCW'(1);
        for (int c = 0; c < 3; c++) begin
          // shift one dividend bit into the remainder, subtract if it fits
          if (!diff[c][CNT]) begin
            rem[c] <= diff[c][CNT-1:0];
            quo[c] <= {quo[c][SUM_W-2:0], 1'b1};
          end else begin
            rem[c] <= rem_sh[c][CNT-1:0];
            quo[c] <= {quo[c][SUM_W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_out.valid <= 1'b0;
    end else if (state == bads_pkg::B_OUT && out_free) begin
      avg_out.valid <= 1'b1;
    end else if (avg_out.ready) begin
      avg_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bads_pkg::B_OUT && out_free) begin
      avg_out.avg_blue  <= quo[0][PW-1:0];
      avg_out.avg_green <= quo[1][PW-1:0];
      avg_out.avg_red   <= quo[2][PW-1:0];
      avg_out.row_end   <= cur.row_end;
      avg_out.frame_end <= cur.frame_end;
    end
  end
endmodule
`default_nettype wire
